>>> src/bls_pkg.sv
// Shared types and constants for the Bresenham line stepper.
`timescale 1ns / 1ps
`default_nettype none

package bls_pkg;

  // Coordinate width of every endpoint and pixel.
  localparam int CoordBits = 12;
  // Bresenham decision value: up to two times a magnitude, plus sign.
  localparam int ErrBits   = CoordBits + 3;
  // Screen size registers.
  localparam int ScrBits   = 12;
  localparam int CmpBits   = (CoordBits > ScrBits) ? CoordBits : ScrBits;

  // Stream payload widths, rounded up to whole bytes.
  localparam int InDataBits  = ((4 * CoordBits + 7) / 8) * 8;
  localparam int OutDataBits = ((2 * CoordBits + 7) / 8) * 8;

  // APB register map.
  localparam int AddrBits  = 3;
  localparam int DataBits  = 32;
  localparam logic RegScreenWidth  = 1'b0;
  localparam logic RegScreenHeight = 1'b1;
  localparam logic [ScrBits-1:0] ScreenWidthReset  = ScrBits'(640);
  localparam logic [ScrBits-1:0] ScreenHeightReset = ScrBits'(480);

  // Command codes carried on the input tuser.
  localparam logic CmdStart = 1'b0;
  localparam logic CmdStep  = 1'b1;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic        [CoordBits-1:0] mag_t;
  typedef logic signed [ErrBits-1:0]   err_t;

  typedef struct packed {
    coord_t cur_x;
    coord_t cur_y;
    coord_t major_end;
    mag_t   abs_dx;
    mag_t   abs_dy;
    err_t   error_term;
    logic   y_major;
    logic   minor_step_up;
    logic   line_active;
  } bls_state_t;

  typedef struct packed {
    logic   valid;
    coord_t pixel_x;
    coord_t pixel_y;
    logic   visible;
    logic   last_pixel;
  } bls_result_t;

endpackage

`default_nettype wire

>>> src/bls_step.sv
// Next-state and pixel logic of the Bresenham line stepper.
`timescale 1ns / 1ps
`default_nettype none

module bls_step (
  input  bls_pkg::bls_state_t  state_i,
  input  logic                 command_i,
  input  bls_pkg::coord_t      start_x_i,
  input  bls_pkg::coord_t      start_y_i,
  input  bls_pkg::coord_t      end_x_i,
  input  bls_pkg::coord_t      end_y_i,
  input  logic [bls_pkg::ScrBits-1:0] screen_width_i,
  input  logic [bls_pkg::ScrBits-1:0] screen_height_i,
  output bls_pkg::bls_state_t  state_o,
  output bls_pkg::bls_result_t result_o
);
  import bls_pkg::*;

  logic signed [CoordBits:0] dx, dy, neg_dx, neg_dy;
  mag_t       abs_dx, abs_dy, abs_minor, abs_major;
  logic       y_major, dx_neg, dy_neg, dx_pos, dy_pos;
  err_t       two_minor, two_major, st_minor, st_major;
  bls_state_t nxt;
  coord_t     major_cur;
  logic       last, produce;
  logic [CmpBits-1:0] ux, uy, uw, uh;

  // Start command: differences, magnitudes and octant.
  always_comb begin
    dx     = {end_x_i[CoordBits-1], end_x_i} - {start_x_i[CoordBits-1], start_x_i};
    dy     = {end_y_i[CoordBits-1], end_y_i} - {start_y_i[CoordBits-1], start_y_i};
    neg_dx = -dx;
    neg_dy = -dy;
    dx_neg = dx[CoordBits];
    dy_neg = dy[CoordBits];
    dx_pos = !dx_neg && (dx != '0);
    dy_pos = !dy_neg && (dy != '0);
    abs_dx = dx_neg ? neg_dx[CoordBits-1:0] : dx[CoordBits-1:0];
    abs_dy = dy_neg ? neg_dy[CoordBits-1:0] : dy[CoordBits-1:0];
    y_major   = abs_dy > abs_dx;
    abs_minor = y_major ? abs_dx : abs_dy;
    abs_major = y_major ? abs_dy : abs_dx;
  end

  // Doubled magnitudes of the stored line for the step update; doubled minor and plain major magnitude for a start.
  always_comb begin
    st_minor = state_i.y_major ? err_t'({2'b00, state_i.abs_dx, 1'b0})
                               : err_t'({2'b00, state_i.abs_dy, 1'b0});
    st_major = state_i.y_major ? err_t'({2'b00, state_i.abs_dy, 1'b0})
                               : err_t'({2'b00, state_i.abs_dx, 1'b0});
    two_minor = err_t'({2'b00, abs_minor, 1'b0});
    two_major = err_t'({3'b000, abs_major});
  end

  always_comb begin
    nxt     = state_i;
    produce = 1'b0;
    if (command_i == CmdStart) begin
      produce           = 1'b1;
      nxt.abs_dx        = abs_dx;
      nxt.abs_dy        = abs_dy;
      nxt.y_major       = y_major;
      nxt.minor_step_up = (dx_neg && dy_neg) || (dx_pos && dy_pos);
      nxt.error_term    = two_minor - two_major;
      // Walk so that the major axis increases.
      if ((y_major ? dy_neg : dx_neg)) begin
        nxt.cur_x     = end_x_i;
        nxt.cur_y     = end_y_i;
        nxt.major_end = y_major ? start_y_i : start_x_i;
      end else begin
        nxt.cur_x     = start_x_i;
        nxt.cur_y     = start_y_i;
        nxt.major_end = y_major ? end_y_i : end_x_i;
      end
    end else if (state_i.line_active) begin
      produce = 1'b1;
      if (state_i.y_major) begin
        nxt.cur_y = state_i.cur_y + coord_t'(1);
      end else begin
        nxt.cur_x = state_i.cur_x + coord_t'(1);
      end
      if (state_i.error_term[ErrBits-1]) begin
        nxt.error_term = state_i.error_term + st_minor;
      end else begin
        nxt.error_term = state_i.error_term + (st_minor - st_major);
        if (state_i.y_major) begin
          nxt.cur_x = state_i.minor_step_up ? state_i.cur_x + coord_t'(1)
                                            : state_i.cur_x - coord_t'(1);
        end else begin
          nxt.cur_y = state_i.minor_step_up ? state_i.cur_y + coord_t'(1)
                                            : state_i.cur_y - coord_t'(1);
        end
      end
    end
  end

  // Pixel tags for the new current position.
  always_comb begin
    major_cur = nxt.y_major ? nxt.cur_y : nxt.cur_x;
    last      = (major_cur == nxt.major_end);
    ux = CmpBits'($unsigned(nxt.cur_x));
    uy = CmpBits'($unsigned(nxt.cur_y));
    uw = CmpBits'(screen_width_i);
    uh = CmpBits'(screen_height_i);

    state_o = nxt;
    if (produce) begin
      state_o.line_active = !last;
    end

    result_o.valid      = produce;
    result_o.pixel_x    = nxt.cur_x;
    result_o.pixel_y    = nxt.cur_y;
    result_o.last_pixel = last;
    result_o.visible    = !nxt.cur_x[CoordBits-1] && !nxt.cur_y[CoordBits-1] &&
                          (ux < uw) && (uy < uh);
  end

endmodule

`default_nettype wire

>>> src/bresenham_line_stepper_top.sv
// Top level of the Bresenham line stepper: stream ports, APB registers, pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Bresenham line stepper for all octants. A start request (tuser = 0) carries two
// signed endpoints and produces the first pixel of the line at once; each step
// request (tuser = 1) produces the next pixel, walking the major axis upward. A
// step request with no line in progress is consumed and produces nothing. Every
// pixel carries a visible flag (inside the screen size registers) on tuser and
// marks the far endpoint with tlast. The block takes one request per cycle unless
// the output stalls, through one input register, then the next-state logic of a
// single add, compare and increment feeding both the line state and the output
// register. The line state loops back through that logic, which sets the rate of
// one pixel per cycle. Screen size registers sit at byte addresses 0 (width) and 4
// (height) and should be written only while the block is idle.

module bresenham_line_stepper_top (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // Fields from bit 0 up: start_x, start_y, end_x, end_y.
  input  logic [bls_pkg::InDataBits-1:0]  s_axis_tdata_i,
  // Fields from bit 0 up: command.
  input  logic                            s_axis_tuser_i,

  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // Fields from bit 0 up: pixel_x, pixel_y.
  output logic [bls_pkg::OutDataBits-1:0] m_axis_tdata_o,
  // Fields from bit 0 up: visible.
  output logic                            m_axis_tuser_o,
  output logic                            m_axis_tlast_o,

  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bls_pkg::AddrBits-1:0]    paddr,
  input  logic [bls_pkg::DataBits-1:0]    pwdata,
  output logic [bls_pkg::DataBits-1:0]    prdata,
  output logic                            pready
);
  import bls_pkg::*;

  logic [ScrBits-1:0] screen_width_q, screen_height_q;

  logic   in_valid_q, in_cmd_q;
  coord_t in_sx_q, in_sy_q, in_ex_q, in_ey_q;

  bls_state_t  state_q, state_d;
  bls_result_t result;

  logic   out_valid_q, out_vis_q, out_last_q;
  coord_t out_x_q, out_y_q;
  logic   advance;

  // Configuration registers. The register index is address bit 2.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= ScreenWidthReset;
      screen_height_q <= ScreenHeightReset;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == RegScreenWidth) begin
        screen_width_q <= pwdata[ScrBits-1:0];
      end else begin
        screen_height_q <= pwdata[ScrBits-1:0];
      end
    end
  end

  always_comb begin
    case (paddr[2])
      RegScreenWidth:  prdata = DataBits'(screen_width_q);
      RegScreenHeight: prdata = DataBits'(screen_height_q);
      default:         prdata = '0;
    endcase
  end

  // The held request moves on when the output register is free or being drained.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_cmd_q <= s_axis_tuser_i;
      in_sx_q  <= s_axis_tdata_i[CoordBits-1:0];
      in_sy_q  <= s_axis_tdata_i[2*CoordBits-1:CoordBits];
      in_ex_q  <= s_axis_tdata_i[3*CoordBits-1:2*CoordBits];
      in_ey_q  <= s_axis_tdata_i[4*CoordBits-1:3*CoordBits];
    end
  end

  bls_step u_step (
    .state_i         (state_q),
    .command_i       (in_cmd_q),
    .start_x_i       (in_sx_q),
    .start_y_i       (in_sy_q),
    .end_x_i         (in_ex_q),
    .end_y_i         (in_ey_q),
    .screen_width_i  (screen_width_q),
    .screen_height_i (screen_height_q),
    .state_o         (state_d),
    .result_o        (result)
  );

  // Line state is updated only by a request that moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && result.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && result.valid) begin
      out_x_q    <= result.pixel_x;
      out_y_q    <= result.pixel_y;
      out_vis_q  <= result.visible;
      out_last_q <= result.last_pixel;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutDataBits'({out_y_q, out_x_q});
  assign m_axis_tuser_o  = out_vis_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

>>> test/bresenham_line_stepper_top_tb.sv
// Self-checking testbench for the Bresenham line stepper: directed table, random lines, APB.
`timescale 1ns / 1ps

module bresenham_line_stepper_top_tb;
  import bls_pkg::*;

  localparam int ClkHalf        = 2;
  localparam int ResetCycles    = 6;
  localparam int IdlePercent    = 23;
  localparam int SettleCycles   = 8;
  localparam int WatchdogLimit  = 4000;
  localparam int NumPhases      = 6;
  localparam int PixelsPerPhase = 180;
  localparam int ReportLimit    = 10;

  localparam logic [AddrBits-1:0] WidthAddr  = AddrBits'({RegScreenWidth, 2'b00});
  localparam logic [AddrBits-1:0] HeightAddr = AddrBits'({RegScreenHeight, 2'b00});

  // One pixel as it leaves the block.
  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   vis;
    logic   last;
  } pixel_t;

  // How a directed row is checked: by the line tracer, against a typed pixel, or as a
  // request that must produce nothing.
  typedef enum logic [1:0] {RowPredict, RowPixel, RowSilent} row_kind_e;

  typedef struct {
    row_kind_e kind;
    logic      cmd;
    int        sx, sy, ex, ey;
    pixel_t    want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                   s_tvalid = 1'b0;
  logic [InDataBits-1:0]  s_tdata  = '0;
  logic                   s_tuser  = 1'b0;
  logic                   s_axis_tready_o;
  logic                   m_axis_tvalid_o;
  logic                   m_tready = 1'b0;
  logic [OutDataBits-1:0] m_axis_tdata_o;
  logic                   m_axis_tuser_o;
  logic                   m_axis_tlast_o;

  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [AddrBits-1:0] paddr   = '0;
  logic [DataBits-1:0] pwdata  = '0;
  logic [DataBits-1:0] prdata;
  logic                pready;

  // Line tracer state, a private copy of what the block holds.
  logic [ScrBits-1:0] scr_w = ScreenWidthReset;
  logic [ScrBits-1:0] scr_h = ScreenHeightReset;
  coord_t pos_x = '0;
  coord_t pos_y = '0;
  coord_t major_stop = '0;
  mag_t   span_x = '0;
  mag_t   span_y = '0;
  err_t   decision = '0;
  logic   walk_y = 1'b0;
  logic   minor_up = 1'b0;
  logic   drawing = 1'b0;

  pixel_t pixel_q[$];
  int     pixels_planned = 0;
  int     fail_count = 0;
  int     quiet_cycles = 0;
  bit     calm = 1'b0;

  always #(ClkHalf) clk_i = ~clk_i;

  bresenham_line_stepper_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= ReportLimit) $display("mismatch: %s", msg);
  endtask

  // Advances the line tracer by one accepted request. A start request reorders the
  // endpoints so the major axis climbs; a step request moves one pixel along it.
  task automatic trace_request(input logic cmd, input logic [InDataBits-1:0] data,
                               output bit made, output pixel_t px);
    coord_t x1, y1, x2, y2;
    int dx, dy;
    made = 1'b0;
    px = '0;
    x1 = data[0 +: CoordBits];
    y1 = data[CoordBits +: CoordBits];
    x2 = data[2*CoordBits +: CoordBits];
    y2 = data[3*CoordBits +: CoordBits];
    if (cmd == CmdStart) begin
      dx = int'(x2) - int'(x1);
      dy = int'(y2) - int'(y1);
      span_x = mag_t'(dx < 0 ? -dx : dx);
      span_y = mag_t'(dy < 0 ? -dy : dy);
      // The minor axis climbs only when both deltas are nonzero and agree in sign.
      minor_up = (dx < 0 && dy < 0) || (dx > 0 && dy > 0);
      walk_y = span_y > span_x;
      if (!walk_y) begin
        decision = err_t'(2 * int'(span_y) - int'(span_x));
        if (dx >= 0) begin
          pos_x = x1; pos_y = y1; major_stop = x2;
        end else begin
          pos_x = x2; pos_y = y2; major_stop = x1;
        end
      end else begin
        decision = err_t'(2 * int'(span_x) - int'(span_y));
        if (dy >= 0) begin
          pos_x = x1; pos_y = y1; major_stop = y2;
        end else begin
          pos_x = x2; pos_y = y2; major_stop = y1;
        end
      end
    end else begin
      // A step with no line in progress is swallowed.
      if (!drawing) return;
      if (!walk_y) begin
        pos_x = coord_t'(int'(pos_x) + 1);
        if (decision < 0) begin
          decision = err_t'(int'(decision) + 2 * int'(span_y));
        end else begin
          pos_y = coord_t'(int'(pos_y) + (minor_up ? 1 : -1));
          decision = err_t'(int'(decision) + 2 * (int'(span_y) - int'(span_x)));
        end
      end else begin
        pos_y = coord_t'(int'(pos_y) + 1);
        if (decision < 0) begin
          decision = err_t'(int'(decision) + 2 * int'(span_x));
        end else begin
          pos_x = coord_t'(int'(pos_x) + (minor_up ? 1 : -1));
          decision = err_t'(int'(decision) + 2 * (int'(span_x) - int'(span_y)));
        end
      end
    end
    px.x = pos_x;
    px.y = pos_y;
    px.vis = (int'(pos_x) >= 0) && (int'(pos_y) >= 0) &&
             (int'(pos_x) < int'(scr_w)) && (int'(pos_y) < int'(scr_h));
    px.last = ((walk_y ? pos_y : pos_x) == major_stop);
    drawing = !px.last;
    made = 1'b1;
  endtask

  function automatic logic [InDataBits-1:0] pack_ends(input int sx, input int sy,
                                                      input int ex, input int ey);
    logic [InDataBits-1:0] d;
    d = '0;
    d[0 +: CoordBits]           = coord_t'(sx);
    d[CoordBits +: CoordBits]   = coord_t'(sy);
    d[2*CoordBits +: CoordBits] = coord_t'(ex);
    d[3*CoordBits +: CoordBits] = coord_t'(ey);
    return d;
  endfunction

  function automatic logic [InDataBits-1:0] random_payload();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[InDataBits-1:0];
  endfunction

  function automatic int clamp_coord(input int v);
    if (v < -(1 << (CoordBits - 1))) return -(1 << (CoordBits - 1));
    if (v > (1 << (CoordBits - 1)) - 1) return (1 << (CoordBits - 1)) - 1;
    return v;
  endfunction

  // Picks a coordinate anywhere, near zero, near the screen edge, or on screen, so the
  // visible flag flips often.
  function automatic int aim_near(input logic [ScrBits-1:0] lim);
    int v;
    case ($urandom_range(0, 3))
      0: v = int'(coord_t'($urandom));
      1: v = int'($urandom_range(0, 40)) - 20;
      2: v = int'(lim) + int'($urandom_range(0, 40)) - 20;
      default: v = int'($urandom_range(0, lim));
    endcase
    return clamp_coord(v);
  endfunction

  function automatic dir_row_t mk_row(input row_kind_e kind, input logic cmd,
                                      input int sx, input int sy, input int ex,
                                      input int ey, input int px, input int py,
                                      input logic vis, input logic last);
    dir_row_t r;
    r.kind = kind;
    r.cmd = cmd;
    r.sx = sx; r.sy = sy; r.ex = ex; r.ey = ey;
    r.want.x = coord_t'(px);
    r.want.y = coord_t'(py);
    r.want.vis = vis;
    r.want.last = last;
    return r;
  endfunction

  // Offers one request, with random idle cycles first unless calm, and records what it
  // should produce once the block has taken it.
  task automatic send_req(input logic cmd, input logic [InDataBits-1:0] data,
                          input row_kind_e kind, input pixel_t typed);
    bit made;
    pixel_t px;
    while (!calm && $urandom_range(0, 99) < IdlePercent) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    trace_request(cmd, data, made, px);
    if (kind == RowPixel) begin
      made = 1'b1;
      px = typed;
    end else if (kind == RowSilent) begin
      made = 1'b0;
    end
    if (made) begin
      pixel_q.push_back(px);
      pixels_planned++;
    end
  endtask

  // Stops offering requests and waits for every pending pixel.
  task automatic drain_pixels();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pixel_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [AddrBits-1:0] addr, input logic [DataBits-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read(input logic [AddrBits-1:0] addr, output logic [DataBits-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    value = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Rewrites and reads back both screen registers once the block has gone quiet. A trailing
  // step with no line may still be in flight after the last pixel, hence the settle cycles.
  task automatic retune_screen(input logic [DataBits-1:0] w, input logic [DataBits-1:0] h);
    logic [DataBits-1:0] back;
    drain_pixels();
    repeat (SettleCycles) @(posedge clk_i);
    apb_write(WidthAddr, w);
    apb_write(HeightAddr, h);
    scr_w = w[ScrBits-1:0];
    scr_h = h[ScrBits-1:0];
    apb_read(WidthAddr, back);
    if (back[ScrBits-1:0] !== scr_w)
      report_mismatch($sformatf("width readback %0d, expected %0d", back[ScrBits-1:0], scr_w));
    apb_read(HeightAddr, back);
    if (back[ScrBits-1:0] !== scr_h)
      report_mismatch($sformatf("height readback %0d, expected %0d", back[ScrBits-1:0], scr_h));
  endtask

  // One random line: mostly short lines near the screen that run to their end and up to two
  // steps beyond, some abandoned midway, and a few spanning the whole coordinate range.
  task automatic random_line();
    int sx, sy, ex, ey, len, steps, pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      sx = int'(coord_t'($urandom));
      sy = int'(coord_t'($urandom));
      ex = int'(coord_t'($urandom));
      ey = int'(coord_t'($urandom));
      steps = $urandom_range(0, 12);
    end else begin
      sx = aim_near(scr_w);
      sy = aim_near(scr_h);
      ex = clamp_coord(sx + int'($urandom_range(0, 30)) - 15);
      ey = clamp_coord(sy + int'($urandom_range(0, 30)) - 15);
      len = (ex > sx) ? ex - sx : sx - ex;
      if (((ey > sy) ? ey - sy : sy - ey) > len) len = (ey > sy) ? ey - sy : sy - ey;
      steps = len + int'($urandom_range(0, 2));
      if (pick < 18) steps = int'($urandom_range(0, len));
    end
    send_req(CmdStart, pack_ends(sx, sy, ex, ey), RowPredict, '0);
    repeat (steps) send_req(CmdStep, random_payload(), RowPredict, '0);
  endtask

  // The receiver stalls at random except during the calm stretch.
  always @(posedge clk_i) m_tready <= calm || ($urandom_range(0, 99) >= IdlePercent);

  // Every pixel taken from the block is matched against the oldest pending one.
  always @(posedge clk_i) begin : check_pixels
    pixel_t want, got;
    if (rst_n && m_axis_tvalid_o && m_tready) begin
      got.x    = m_axis_tdata_o[0 +: CoordBits];
      got.y    = m_axis_tdata_o[CoordBits +: CoordBits];
      got.vis  = m_axis_tuser_o;
      got.last = m_axis_tlast_o;
      if (pixel_q.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel x=%0d y=%0d vis=%0b last=%0b",
                                  got.x, got.y, got.vis, got.last));
      end else begin
        want = pixel_q.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.vis !== want.vis ||
            got.last !== want.last)
          report_mismatch($sformatf("pixel x=%0d y=%0d vis=%0b last=%0b, expected %0d %0d %0b %0b",
                                    got.x, got.y, got.vis, got.last,
                                    want.x, want.y, want.vis, want.last));
      end
    end
  end

  // Ends the run when neither side has moved a request for too long.
  always @(posedge clk_i) begin
    if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("[bresenham_line_stepper_top] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t rows[$];
    logic [InDataBits-1:0] data;
    logic [DataBits-1:0] phase_w[NumPhases];
    logic [DataBits-1:0] phase_h[NumPhases];
    int goal;
    bit paused;
    // Screen settings per phase: reset values, the smallest, the largest of the usual
    // range, all ones, a mixed pair and a random pair.
    phase_w = '{32'd640, 32'd1, 32'd2048, 32'd4095, 32'd2048, 32'd0};
    phase_h = '{32'd480, 32'd1, 32'd2048, 32'd4095, 32'd1, 32'd0};
    phase_w[NumPhases-1] = DataBits'($urandom_range(1, 2048));
    phase_h[NumPhases-1] = DataBits'($urandom_range(1, 2048));
    paused = 1'b0;

    // Step straight after reset, then a single-pixel line and a step past its end.
    rows.push_back(mk_row(RowSilent, CmdStep, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    rows.push_back(mk_row(RowPixel, CmdStart, 5, 5, 5, 5, 5, 5, 1'b1, 1'b1));
    rows.push_back(mk_row(RowSilent, CmdStep, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    // Shallow line climbing in both axes, walked to the end and one step beyond.
    rows.push_back(mk_row(RowPredict, CmdStart, 0, 0, 3, 1, 0, 0, 1'b0, 1'b0));
    repeat (4) rows.push_back(mk_row(RowPredict, CmdStep, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    // Steep line with both deltas negative, so the endpoints swap.
    rows.push_back(mk_row(RowPredict, CmdStart, 2, 0, 0, -3, 0, 0, 1'b0, 1'b0));
    repeat (3) rows.push_back(mk_row(RowPredict, CmdStep, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    // Steep line whose minor axis falls.
    rows.push_back(mk_row(RowPredict, CmdStart, 0, 3, 2, 0, 0, 0, 1'b0, 1'b0));
    repeat (3) rows.push_back(mk_row(RowPredict, CmdStep, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    // Full-range diagonals, each abandoned by the next start.
    rows.push_back(mk_row(RowPixel, CmdStart, -2048, -2048, 2047, 2047,
                          -2048, -2048, 1'b0, 1'b0));
    rows.push_back(mk_row(RowPredict, CmdStep, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    rows.push_back(mk_row(RowPixel, CmdStart, 2047, 2047, -2048, -2048,
                          -2048, -2048, 1'b0, 1'b0));
    rows.push_back(mk_row(RowPixel, CmdStart, 2047, -2048, -2048, 2047,
                          -2048, 2047, 1'b0, 1'b0));
    rows.push_back(mk_row(RowPredict, CmdStep, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    // Single pixels on the screen corners and just off the right, bottom and left edges.
    rows.push_back(mk_row(RowPixel, CmdStart, 639, 479, 639, 479, 639, 479, 1'b1, 1'b1));
    rows.push_back(mk_row(RowPixel, CmdStart, 640, 479, 640, 479, 640, 479, 1'b0, 1'b1));
    rows.push_back(mk_row(RowPixel, CmdStart, 0, 480, 0, 480, 0, 480, 1'b0, 1'b1));
    rows.push_back(mk_row(RowPixel, CmdStart, -1, 0, -1, 0, -1, 0, 1'b0, 1'b1));
    rows.push_back(mk_row(RowPixel, CmdStart, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1));

    repeat (ResetCycles) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].cmd == CmdStart) data = pack_ends(rows[i].sx, rows[i].sy, rows[i].ex, rows[i].ey);
      else data = random_payload();
      send_req(rows[i].cmd, data, rows[i].kind, rows[i].want);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      retune_screen(phase_w[ph], phase_h[ph]);
      // One phase runs with neither side idling at all.
      calm = (ph == 3);
      goal = pixels_planned + PixelsPerPhase;
      while (pixels_planned < goal) begin
        random_line();
        // Halfway through one phase the sender holds off until the block has emptied.
        if (ph == 1 && !paused && pixels_planned >= goal - PixelsPerPhase / 2) begin
          drain_pixels();
          paused = 1'b1;
        end
      end
    end
    calm = 1'b0;

    drain_pixels();
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0 && pixel_q.size() == 0) begin
      $display("[bresenham_line_stepper_top] OK");
    end else begin
      $display("[bresenham_line_stepper_top] ERROR");
    end
    $finish;
  end

endmodule

>>> bresenham_line_stepper_top.f
src/bls_pkg.sv
src/bls_step.sv
src/bresenham_line_stepper_top.sv
test/bresenham_line_stepper_top_tb.sv
